FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLKED(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed: label");

// Clocked assertion that also checks during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed: label");

`endif

FILE: hdl/lifo_so_pkg.sv
// Package with the codes, defaults and types of the overwrite-oldest stack.
package lifo_so_pkg;

	// Default sizes of the stack.
	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned WORD_WIDTH_DEF = 32;

	// Fixed widths of the request and result fields.
	localparam int unsigned OP_W     = 2;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Operation codes.
	localparam op_t OP_PUSH  = 2'd0;
	localparam op_t OP_POP   = 2'd1;
	localparam op_t OP_FORCE = 2'd2;

	// Status codes.
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
	localparam status_t ST_DISCARD = 2'd3;

	// Registered result flags handed from the controller to the top level.
	typedef struct packed {
		logic    done;
		logic    pop_valid;
		status_t status;
	} result_t;

endpackage

FILE: hdl/lifo_so_ram.sv
// Entry memory of the stack: one write port and one registered read port.
module lifo_so_ram #(
	parameter int unsigned CAPACITY   = lifo_so_pkg::CAPACITY_DEF,
	parameter int unsigned WORD_WIDTH = lifo_so_pkg::WORD_WIDTH_DEF,
	localparam int unsigned PtrW      = $clog2(CAPACITY)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [PtrW-1:0]       wr_addr,
	input  logic [WORD_WIDTH-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [PtrW-1:0]       rd_addr,
	output logic [WORD_WIDTH-1:0] rd_data
);

	logic [WORD_WIDTH-1:0] mem [CAPACITY];
	logic [WORD_WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/lifo_so_ctrl.sv
// Pointer and count control of the stack ring, with the registered result flags.
module lifo_so_ctrl #(
	parameter int unsigned CAPACITY   = lifo_so_pkg::CAPACITY_DEF,
	parameter int unsigned WORD_WIDTH = lifo_so_pkg::WORD_WIDTH_DEF,
	localparam int unsigned PtrW      = $clog2(CAPACITY),
	localparam int unsigned CntW      = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  lifo_so_pkg::op_t            operation,
	input  logic [lifo_so_pkg::DATA_W-1:0] data_in,
	output logic                        wr_en,
	output logic [PtrW-1:0]             wr_addr,
	output logic [WORD_WIDTH-1:0]       wr_data,
	output logic                        rd_en,
	output logic [PtrW-1:0]             rd_addr,
	output lifo_so_pkg::result_t        result,
	output logic [CntW-1:0]             count
);

	logic [PtrW-1:0] bottom_q;
	logic [CntW-1:0] count_q;
	lifo_so_pkg::result_t result_q;

	logic [PtrW-1:0] bottom_d;
	logic [CntW-1:0] count_d;
	lifo_so_pkg::result_t result_d;
	logic full;
	logic empty;
	logic [PtrW-1:0] top_free_slot;
	logic [PtrW-1:0] top_used_slot;
	logic [PtrW-1:0] bottom_next;
	logic [CntW-1:0] count_less;
	logic [WORD_WIDTH+lifo_so_pkg::DATA_W-1:0] in_ext;

	// Ring addition of an offset below the capacity to a slot index.
	function automatic logic [PtrW-1:0] ring_add(input logic [PtrW-1:0] base,
			input logic [PtrW-1:0] off);
		logic [PtrW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (PtrW+1)'(CAPACITY)) begin
			sum = sum - (PtrW+1)'(CAPACITY);
		end
		return sum[PtrW-1:0];
	endfunction

	// Slot addresses around the current top and bottom.
	assign full          = (count_q == CntW'(CAPACITY));
	assign empty         = (count_q == '0);
	assign count_less    = count_q - CntW'(1);
	assign top_free_slot = ring_add(bottom_q, count_q[PtrW-1:0]);
	assign top_used_slot = ring_add(bottom_q, count_less[PtrW-1:0]);
	assign bottom_next   = ring_add(bottom_q, PtrW'(1));

	// The pushed word is cut or widened to the stored width.
	assign in_ext  = {{WORD_WIDTH{1'b0}}, data_in};
	assign wr_data = in_ext[WORD_WIDTH-1:0];

	// Decode the request into memory accesses and the next pointer state.
	always_comb begin
		bottom_d           = bottom_q;
		count_d            = count_q;
		wr_en              = 1'b0;
		wr_addr            = top_free_slot;
		rd_en              = 1'b0;
		rd_addr            = top_used_slot;
		result_d.done      = accept;
		result_d.pop_valid = 1'b0;
		result_d.status    = lifo_so_pkg::ST_OK;
		if (accept) begin
			case (operation)
				lifo_so_pkg::OP_PUSH, lifo_so_pkg::OP_FORCE: begin
					if (!full) begin
						wr_en   = 1'b1;
						count_d = count_q + CntW'(1);
					end else if (operation == lifo_so_pkg::OP_FORCE) begin
						// The new word overwrites the oldest slot and becomes the top.
						wr_en           = 1'b1;
						wr_addr         = bottom_q;
						bottom_d        = bottom_next;
						result_d.status = lifo_so_pkg::ST_DISCARD;
					end else begin
						result_d.status = lifo_so_pkg::ST_FULL;
					end
				end
				lifo_so_pkg::OP_POP: begin
					if (empty) begin
						result_d.status = lifo_so_pkg::ST_EMPTY;
					end else begin
						rd_en              = 1'b1;
						count_d            = count_less;
						result_d.pop_valid = 1'b1;
					end
				end
				default: begin
					// Unused codes leave the state as it is.
				end
			endcase
		end
	end

	// Pointer, count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q <= '0;
			count_q  <= '0;
			result_q <= '0;
		end else begin
			bottom_q <= bottom_d;
			count_q  <= count_d;
			result_q <= result_d;
		end
	end

	assign result = result_q;
	assign count  = count_q;

endmodule

FILE: hdl/lifo_stack_overwrite_oldest_core.sv
// Top level of the bounded stack with an overwrite-oldest push.
// The result of a request appears with done in the cycle after it is taken.
// Throughput: one request per cycle; busy stays low, since each request makes
// at most one access to the entry memory.
// Reset: arst_n clears the count and the bottom pointer, so the stack is empty;
// entries are not cleared and are read only after they were written.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module lifo_stack_overwrite_oldest_core #(
	parameter int unsigned CAPACITY   = lifo_so_pkg::CAPACITY_DEF,
	parameter int unsigned WORD_WIDTH = lifo_so_pkg::WORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [lifo_so_pkg::OP_W-1:0]         operation,
	input  logic [lifo_so_pkg::DATA_W-1:0]       data_in,
	output logic                                 done,
	output logic [lifo_so_pkg::DATA_W-1:0]       pop_data,
	output logic                                 pop_valid,
	output logic [lifo_so_pkg::STATUS_W-1:0]     status,
	output logic [lifo_so_pkg::COUNT_W-1:0]      entry_count,
	output logic                                 is_empty,
	output logic                                 is_full
);

	localparam int unsigned PtrW = $clog2(CAPACITY);
	localparam int unsigned CntW = $clog2(CAPACITY + 1);

	logic                  accept;
	logic                  wr_en;
	logic [PtrW-1:0]       wr_addr;
	logic [WORD_WIDTH-1:0] wr_data;
	logic                  rd_en;
	logic [PtrW-1:0]       rd_addr;
	logic [WORD_WIDTH-1:0] rd_data;
	lifo_so_pkg::result_t  result;
	logic [CntW-1:0]       count;
	logic [WORD_WIDTH+lifo_so_pkg::DATA_W-1:0] pop_ext;
	logic [CntW+lifo_so_pkg::COUNT_W-1:0]      count_ext;

	// A request is taken whenever start is high; the block never holds off.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	lifo_so_ctrl #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.data_in   (data_in),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.result    (result),
		.count     (count)
	);

	lifo_so_ram #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result fields; the popped word is shown only with a successful pop.
	assign pop_ext     = {{lifo_so_pkg::DATA_W{1'b0}}, rd_data};
	assign count_ext   = {{lifo_so_pkg::COUNT_W{1'b0}}, count};
	assign done        = result.done;
	assign pop_valid   = result.pop_valid;
	assign status      = result.status;
	assign pop_data    = result.pop_valid ? pop_ext[lifo_so_pkg::DATA_W-1:0] : '0;
	assign entry_count = count_ext[lifo_so_pkg::COUNT_W-1:0];
	assign is_empty    = (count == '0);
	assign is_full     = (count == CntW'(CAPACITY));

	// Every taken request gives exactly one result in the next cycle.
	`ASSERT_CLKED(a_done_follows, clk, arst_n, accept |=> done)
	`ASSERT_CLKED(a_no_spurious_done, clk, arst_n, !accept |=> !done)
	// A discard happens only on a full stack, which stays full.
	`ASSERT_CLKED(a_discard_full, clk, arst_n,
		(done && status == lifo_so_pkg::ST_DISCARD) |-> (is_full && !pop_valid))
	// A successful pop leaves room and reports no error.
	`ASSERT_CLKED(a_pop_leaves_room, clk, arst_n,
		(done && pop_valid) |-> (!is_full && status == lifo_so_pkg::ST_OK))

endmodule
